### design/flcc_pkg.sv
package flcc_pkg;

  // framing bytes
  localparam logic [7:0] MARK       = 8'h33;
  localparam logic [7:0] MARK_START = 8'h01;
  localparam logic [7:0] MARK_END   = 8'h03;
  localparam logic [7:0] ESCAPE     = 8'h02;
  localparam logic [7:0] CMD_RUN    = 8'h02;

  // frame layout
  localparam int CH_POS     = 4;
  localparam int CMD_POS    = 5;
  localparam int UNLOCK_POS = 6;
  localparam int FLASH_POS  = 8;

  // width of each result bit vector
  localparam int OUT_W = 25;

  // per-channel timer word
  typedef struct packed {
    logic [15:0] unlock_left;
    logic [15:0] flash_period;
    logic [15:0] flash_left;
  } chan_word_t;

  typedef struct packed {
    logic take;       // latch the accepted item, clear result flags
    logic byte_step;  // run the deframer on the latched byte
    logic finish;     // frame end: decode buffer, start channel
    logic rd;         // read timer word of the indexed channel
    logic load;       // load result register
  } flcc_cmd_t;

  typedef struct packed {
    logic end_hit;    // latched byte ends a frame
    logic out_free;   // result register can take a new item
  } flcc_status_t;

endpackage

### design/flcc_ctrl.sv
module flcc_ctrl #(
  parameter int CHANNELS = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_ready,
  input  flcc_pkg::flcc_status_t status,
  output flcc_pkg::flcc_cmd_t    cmd,
  output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] idx
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BYTE   = 3'd1;
  localparam logic [2:0] S_FINISH = 3'd2;
  localparam logic [2:0] S_TICK   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]    state, state_next;
  logic [IW-1:0] idx_next;
  logic          last_ch;

  assign last_ch = (idx == IW'(CHANNELS - 1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          idx_next   = '0;
          state_next = in_mode ? S_TICK : S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.byte_step = 1'b1;
        state_next    = status.end_hit ? S_FINISH : S_RESULT;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_RESULT;
      end
      S_TICK: begin
        cmd.rd = 1'b1;
        if (last_ch) begin
          state_next = S_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DRAIN: begin
        // last write-back lands here
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

### design/flcc_datapath.sv
module flcc_datapath #(
  parameter int CHANNELS    = 25,
  parameter int FRAME_BYTES = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  flcc_pkg::flcc_cmd_t    cmd,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] idx,
  input  logic [7:0]             in_byte,
  output flcc_pkg::flcc_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [flcc_pkg::OUT_W-1:0] out_lock,
  output logic [flcc_pkg::OUT_W-1:0] out_led,
  output logic                   out_done,
  output logic                   out_accepted
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = $clog2(FRAME_BYTES + 1);

  // deframer state
  logic [7:0]    byte_q;
  logic          in_frame, after_marker, escape_pending;
  logic [CW-1:0] byte_count;
  logic [7:0]    frame_buf [FRAME_BYTES];
  logic          done_q, acc_q;

  // channel state
  logic [CHANNELS-1:0] active, led;
  flcc_pkg::chan_word_t mem [CHANNELS];
  flcc_pkg::chan_word_t rd_word, wr_word;
  logic [IW-1:0]        wr_addr;
  logic                 wr_en;
  logic                 rd_v;
  logic [IW-1:0]        rd_k;

  // deframer decode
  logic          esc_mark, start_hit, end_hit, out_free, buf_wr, buf_clr;
  logic [CW-1:0] buf_wa;

  // frame decode
  logic [7:0]    ch_byte;
  logic          frame_ok;
  logic [IW-1:0] fin_k;

  assign esc_mark  = escape_pending && (byte_q == flcc_pkg::MARK);
  assign start_hit = after_marker && (byte_q == flcc_pkg::MARK_START);
  assign end_hit   = in_frame && after_marker && (byte_q == flcc_pkg::MARK_END);
  // escaped mark replaces the stored escape byte
  assign buf_wr  = cmd.byte_step && in_frame &&
                   (esc_mark ? (byte_count != '0) : (byte_count < CW'(FRAME_BYTES)));
  assign buf_wa  = esc_mark ? byte_count - 1'b1 : byte_count;
  assign buf_clr = (cmd.byte_step && start_hit) || cmd.finish;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_buf[i] <= '0;
      end
    end else begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        if (buf_clr) begin
          frame_buf[i] <= '0;
        end else if (buf_wr && (buf_wa == CW'(i))) begin
          frame_buf[i] <= byte_q;
        end
      end
    end
  end

  assign ch_byte  = frame_buf[flcc_pkg::CH_POS];
  assign frame_ok = (ch_byte != 8'd0) && (ch_byte <= 8'(CHANNELS)) &&
                    (frame_buf[flcc_pkg::CMD_POS] == flcc_pkg::CMD_RUN);
  assign fin_k    = IW'(ch_byte - 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      after_marker   <= 1'b0;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      done_q         <= 1'b0;
      acc_q          <= 1'b0;
    end else begin
      if (cmd.take) begin
        done_q <= 1'b0;
        acc_q  <= 1'b0;
      end
      if (cmd.byte_step) begin
        if (start_hit) begin
          in_frame   <= 1'b1;
          byte_count <= '0;
        end else if (in_frame && !esc_mark && (byte_count < CW'(FRAME_BYTES))) begin
          byte_count <= byte_count + 1'b1;
        end
        after_marker   <= (byte_q == flcc_pkg::MARK) && !escape_pending;
        escape_pending <= (byte_q == flcc_pkg::ESCAPE);
        done_q         <= end_hit;
      end
      if (cmd.finish) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
        acc_q      <= frame_ok;
      end
    end
  end

  // tick: read one channel per cycle, write it back the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_word <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  logic tk_act, tk_off, tk_toggle;
  flcc_pkg::chan_word_t tk_word;

  assign tk_act = rd_v && active[rd_k];

  always_comb begin
    tk_word   = rd_word;
    tk_off    = 1'b0;
    tk_toggle = 1'b0;
    if (rd_word.unlock_left <= 16'd1) begin
      tk_word.unlock_left = '0;
      tk_off              = 1'b1;
    end else begin
      tk_word.unlock_left = rd_word.unlock_left - 16'd1;
      if (rd_word.flash_period != '0) begin
        if (rd_word.flash_left <= 16'd1) begin
          tk_toggle          = 1'b1;
          tk_word.flash_left = rd_word.flash_period;
        end else begin
          tk_word.flash_left = rd_word.flash_left - 16'd1;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_k;
    wr_word = tk_word;
    if (cmd.finish && frame_ok) begin
      wr_en                = 1'b1;
      wr_addr              = fin_k;
      wr_word.unlock_left  = {frame_buf[flcc_pkg::UNLOCK_POS],
                              frame_buf[flcc_pkg::UNLOCK_POS + 1]};
      wr_word.flash_period = {frame_buf[flcc_pkg::FLASH_POS],
                              frame_buf[flcc_pkg::FLASH_POS + 1]};
      wr_word.flash_left   = wr_word.flash_period;
    end else if (tk_act) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      led    <= '0;
    end else if (cmd.finish && frame_ok) begin
      active[fin_k] <= 1'b1;
      led[fin_k]    <= 1'b0;
    end else if (tk_act) begin
      if (tk_off) begin
        active[rd_k] <= 1'b0;
        led[rd_k]    <= 1'b0;
      end else if (tk_toggle) begin
        led[rd_k] <= !led[rd_k];
      end
    end
  end

  // result register
  logic [flcc_pkg::OUT_W-1:0] lock_vec, led_vec;

  generate
    if (CHANNELS >= flcc_pkg::OUT_W) begin : g_trunc
      assign lock_vec = active[flcc_pkg::OUT_W-1:0];
      assign led_vec  = led[flcc_pkg::OUT_W-1:0];
    end else begin : g_pad
      assign lock_vec = {{(flcc_pkg::OUT_W - CHANNELS){1'b0}}, active};
      assign led_vec  = {{(flcc_pkg::OUT_W - CHANNELS){1'b0}}, led};
    end
  endgenerate

  assign out_free = !out_valid || out_ready;
  assign status   = {end_hit, out_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_lock     <= lock_vec;
      out_led      <= led_vec;
      out_done     <= done_q;
      out_accepted <= acc_q;
    end
  end

endmodule

### design/framed_lock_channel_controller_core.sv
// Framed lock channel controller.
// Input stream: one item per received UART byte (s_axis_tuser = 0) or per
// 1 ms tick (s_axis_tuser = 1). Bytes are deframed into a small buffer; a
// completed run command frame (re)starts a lock channel with an unlock time
// and an LED flash period. Ticks count every active channel down.
// Output stream: one item per input item, carrying the lock and LED levels
// after that item, with tlast set when the byte ended a frame.
// A byte passes a deframer step, a byte that ends a frame also a decode
// step, and a tick a channel walk and a drain step, before the result is
// loaded. A tick walks the channel timer memory one entry per cycle
// through its single read and write port; one item is in work at a time
// and the next is taken the cycle after the result is loaded.
// The result register frees the input side: the next item is accepted while
// a result still waits, and the block only holds in its last step while the
// receiver stalls with a result unread.
// Reset clears framing state, all channels (locks and LEDs off) and the
// result valid flag; timer memory needs no clearing.
module framed_lock_channel_controller_core #(
  parameter int CHANNELS    = 25,
  parameter int FRAME_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [24:0] lock_outputs, [49:25] led_outputs,
                                      // [50] command_accepted, [55:51] zero
  output logic        m_axis_tlast    // frame_done
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  flcc_pkg::flcc_cmd_t    cmd;
  flcc_pkg::flcc_status_t status;
  logic [IW-1:0]          idx;
  logic [flcc_pkg::OUT_W-1:0] lock_q, led_q;
  logic                   acc_q;

  flcc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx)
  );

  flcc_datapath #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx          (idx),
    .in_byte      (s_axis_tdata),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_lock     (lock_q),
    .out_led      (led_q),
    .out_done     (m_axis_tlast),
    .out_accepted (acc_q)
  );

  assign m_axis_tdata = {5'b0, acc_q, led_q, lock_q};

endmodule
